FILE: src/bcd_up_down_stopwatch_core_macros.svh
// ----------------------------------------------------------------------------
// bcd stopwatch assertion macros
// shared property wrappers, clocked on clk and masked during rst
// ----------------------------------------------------------------------------
`ifndef BCD_UP_DOWN_STOPWATCH_CORE_MACROS_SVH
`define BCD_UP_DOWN_STOPWATCH_CORE_MACROS_SVH

// condition must hold at every edge out of reset
`define BSW_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define BSW_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/bcd_sw_pkg.sv
// ----------------------------------------------------------------------------
// bcd_sw_pkg
// types and codes shared by the stopwatch core and its channel interfaces
// ----------------------------------------------------------------------------
package bcd_sw_pkg;

  localparam logic [3:0] UNITS_MAX = 4'd9;
  localparam logic [2:0] TENS_MAX  = 3'd5;

  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_CLEAR    = 3'd1,
    KIND_PAUSE    = 3'd2,
    KIND_RESUME   = 3'd3,
    KIND_TOGGLE   = 3'd4,
    KIND_ADJ_UP   = 3'd5,
    KIND_ADJ_DOWN = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    FIELD_SEC = 2'd0,
    FIELD_MIN = 2'd1,
    FIELD_HRS = 2'd2
  } field_sel_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] field_select;
  } in_item_t;

  typedef struct packed {
    logic [3:0] sec_units_digit;
    logic [2:0] sec_tens_digit;
    logic [3:0] min_units_digit;
    logic [2:0] min_tens_digit;
    logic [3:0] hrs_units_digit;
    logic [2:0] hrs_tens_digit;
    logic       counting_up;
    logic       running;
    logic       alarm;
  } out_item_t;

  // one two-digit field, 00..59
  typedef struct packed {
    logic [3:0] units;
    logic [2:0] tens;
  } bcd_field_t;

endpackage

FILE: src/bcd_sw_in_if.sv
// ----------------------------------------------------------------------------
// bcd_sw_in_if
// event channel into the stopwatch: valid/ready with one event per beat
// ----------------------------------------------------------------------------
interface bcd_sw_in_if
  import bcd_sw_pkg::*;
  ;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/bcd_sw_out_if.sv
// ----------------------------------------------------------------------------
// bcd_sw_out_if
// result channel out of the stopwatch: valid/ready with one snapshot per beat
// ----------------------------------------------------------------------------
interface bcd_sw_out_if
  import bcd_sw_pkg::*;
  ;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/bcd_up_down_stopwatch_core.sv
// ----------------------------------------------------------------------------
// bcd_up_down_stopwatch_core
// hh:mm:ss bcd up/down stopwatch, one event in and one state snapshot out
// ----------------------------------------------------------------------------
//
//   channel   dir   payload                                 beat
//   in_ch     in    kind, field_select                      one event
//   out_ch    out   six bcd digits, counting_up, running,   state after
//                   alarm                                   that event
//
// one event per cycle; its snapshot appears on out_ch the cycle after accept
// the count registers double as the result register, so in_ch stays ready
// while the pending snapshot is being taken (out_ch.ready high)
// in_ch stalls only while a snapshot waits and out_ch.ready is low
// rst is synchronous: 00:00:00, counting up, running, alarm clear, no result
`include "bcd_up_down_stopwatch_core_macros.svh"

module bcd_up_down_stopwatch_core
  import bcd_sw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  bcd_sw_in_if.sink          in_ch,
  bcd_sw_out_if.source       out_ch
);

  typedef struct packed {
    logic       carry;
    bcd_field_t f;
  } step_t;

  bcd_field_t sec, mins, hrs;
  bcd_field_t sec_next, mins_next, hrs_next;
  logic       direction_up, direction_up_next;
  logic       run_enable, run_enable_next;
  logic       alarm_flag, alarm_flag_next;
  logic       out_valid;
  logic       accept;

  step_t      sec_up, min_up, hrs_up;
  step_t      sec_dn, min_dn, hrs_dn;
  bcd_field_t adj_f, adj_inc, adj_dec;
  logic       all_max, all_zero;

  function automatic logic at_max(bcd_field_t f);
    return (f.units >= UNITS_MAX) && (f.tens >= TENS_MAX);
  endfunction

  function automatic logic is_zero(bcd_field_t f);
    return (f.units == '0) && (f.tens == '0);
  endfunction

  function automatic step_t wrap_inc(bcd_field_t f);
    step_t r;
    r.carry = 1'b0;
    r.f     = f;
    if (f.units < UNITS_MAX) begin
      r.f.units = f.units + 4'd1;
    end else begin
      r.f.units = '0;
      if (f.tens < TENS_MAX) begin
        r.f.tens = f.tens + 3'd1;
      end else begin
        r.f.tens = '0;
        r.carry  = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic step_t wrap_dec(bcd_field_t f);
    step_t r;
    r.carry = 1'b0;
    r.f     = f;
    if (f.units != '0) begin
      r.f.units = f.units - 4'd1;
    end else begin
      r.f.units = UNITS_MAX;
      if (f.tens != '0) begin
        r.f.tens = f.tens - 3'd1;
      end else begin
        r.f.tens = TENS_MAX;
        r.carry  = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic bcd_field_t sat_inc(bcd_field_t f);
    bcd_field_t r;
    r = f;
    if (f.units >= UNITS_MAX) begin
      if (f.tens >= TENS_MAX) begin
        r.units = UNITS_MAX;
        r.tens  = TENS_MAX;
      end else begin
        r.units = '0;
        r.tens  = f.tens + 3'd1;
      end
    end else begin
      r.units = f.units + 4'd1;
    end
    return r;
  endfunction

  function automatic bcd_field_t sat_dec(bcd_field_t f);
    bcd_field_t r;
    r = f;
    if (f.units == '0) begin
      if (f.tens != '0) begin
        r.units = UNITS_MAX;
        r.tens  = f.tens - 3'd1;
      end
    end else begin
      r.units = f.units - 4'd1;
    end
    return r;
  endfunction

  assign accept = in_ch.valid & in_ch.ready;
  assign in_ch.ready = ~out_valid | out_ch.ready;

  // per-field step candidates, chained through carry/borrow below
  assign sec_up   = wrap_inc(sec);
  assign min_up   = wrap_inc(mins);
  assign hrs_up   = wrap_inc(hrs);
  assign sec_dn   = wrap_dec(sec);
  assign min_dn   = wrap_dec(mins);
  assign hrs_dn   = wrap_dec(hrs);
  assign all_max  = at_max(sec) & at_max(mins) & at_max(hrs);
  assign all_zero = is_zero(sec) & is_zero(mins) & is_zero(hrs);

  always_comb begin
    case (in_ch.data.field_select)
      FIELD_SEC: adj_f = sec;
      FIELD_MIN: adj_f = mins;
      default:   adj_f = hrs;
    endcase
  end

  assign adj_inc = sat_inc(adj_f);
  assign adj_dec = sat_dec(adj_f);

  always_comb begin
    sec_next          = sec;
    mins_next         = mins;
    hrs_next          = hrs;
    direction_up_next = direction_up;
    run_enable_next   = run_enable;
    alarm_flag_next   = alarm_flag;
    case (in_ch.data.kind)
      KIND_TICK: begin
        if (run_enable) begin
          alarm_flag_next = 1'b0;
          if (direction_up) begin
            if (all_max) begin
              sec_next  = '{units: UNITS_MAX, tens: TENS_MAX};
              mins_next = '{units: UNITS_MAX, tens: TENS_MAX};
              hrs_next  = '{units: UNITS_MAX, tens: TENS_MAX};
            end else begin
              sec_next = sec_up.f;
              if (sec_up.carry) begin
                mins_next = min_up.f;
                if (min_up.carry) begin
                  hrs_next = hrs_up.f;
                end
              end
            end
          end else if (all_zero) begin
            alarm_flag_next = 1'b1;
          end else begin
            sec_next = sec_dn.f;
            if (sec_dn.carry) begin
              mins_next = min_dn.f;
              if (min_dn.carry) begin
                hrs_next = hrs_dn.f;
              end
            end
          end
        end
      end
      KIND_CLEAR: begin
        sec_next        = '0;
        mins_next       = '0;
        hrs_next        = '0;
        alarm_flag_next = 1'b0;
      end
      KIND_PAUSE:  run_enable_next = 1'b0;
      KIND_RESUME: run_enable_next = 1'b1;
      KIND_TOGGLE: direction_up_next = ~direction_up;
      KIND_ADJ_UP, KIND_ADJ_DOWN: begin
        case (in_ch.data.field_select)
          FIELD_SEC: sec_next  = (in_ch.data.kind == KIND_ADJ_UP) ? adj_inc : adj_dec;
          FIELD_MIN: mins_next = (in_ch.data.kind == KIND_ADJ_UP) ? adj_inc : adj_dec;
          FIELD_HRS: hrs_next  = (in_ch.data.kind == KIND_ADJ_UP) ? adj_inc : adj_dec;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sec          <= '0;
      mins         <= '0;
      hrs          <= '0;
      direction_up <= 1'b1;
      run_enable   <= 1'b1;
      alarm_flag   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        sec          <= sec_next;
        mins         <= mins_next;
        hrs          <= hrs_next;
        direction_up <= direction_up_next;
        run_enable   <= run_enable_next;
        alarm_flag   <= alarm_flag_next;
        out_valid    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // the live state is the snapshot; it only moves on accept
  assign out_ch.valid                = out_valid;
  assign out_ch.data.sec_units_digit = sec.units;
  assign out_ch.data.sec_tens_digit  = sec.tens;
  assign out_ch.data.min_units_digit = mins.units;
  assign out_ch.data.min_tens_digit  = mins.tens;
  assign out_ch.data.hrs_units_digit = hrs.units;
  assign out_ch.data.hrs_tens_digit  = hrs.tens;
  assign out_ch.data.counting_up     = direction_up;
  assign out_ch.data.running         = run_enable;
  assign out_ch.data.alarm           = alarm_flag;

  `BSW_ASSERT_ALWAYS(a_digits_in_range,
    sec.units <= UNITS_MAX && sec.tens <= TENS_MAX &&
    mins.units <= UNITS_MAX && mins.tens <= TENS_MAX &&
    hrs.units <= UNITS_MAX && hrs.tens <= TENS_MAX,
    "bcd digit left its range")
  `BSW_ASSERT_NEXT(a_accept_gives_result, accept, out_valid,
    "accepted event produced no result")
  `BSW_ASSERT_NEXT(a_paused_tick_holds,
    accept && in_ch.data.kind == KIND_TICK && !run_enable,
    $stable(sec) && $stable(mins) && $stable(hrs) && $stable(alarm_flag),
    "tick changed state while paused")
  `BSW_ASSERT_NEXT(a_clear_zeroes,
    accept && in_ch.data.kind == KIND_CLEAR,
    all_zero && !alarm_flag,
    "clear left count or alarm set")

endmodule

FILE: verif/bcd_up_down_stopwatch_core_tb.sv
// ----------------------------------------------------------------------------
// bcd_up_down_stopwatch_core_tb
// drives stopwatch events through the valid/ready input channel with random
// gaps and back-pressure, predicts each state snapshot in a local copy of the
// hh:mm:ss counter and checks every result beat field by field, in order
// ----------------------------------------------------------------------------
module bcd_up_down_stopwatch_core_tb
  import bcd_sw_pkg::*;
  ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam logic [1:0] FIELD_NONE  = 2'd3;

  localparam int unsigned ITEM_TARGET  = 1200;
  localparam int unsigned IDLE_PCT     = 23;
  localparam int unsigned CALM_START   = 300;
  localparam int unsigned CALM_END     = 1100;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic clk;
  logic rst;

  bcd_sw_in_if  in_ch ();
  bcd_sw_out_if out_ch ();

  bcd_up_down_stopwatch_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  in_item_t    pending_events[$];
  out_item_t   expected_snapshots[$];
  int unsigned cycle_count;
  int unsigned stall_count;
  int unsigned error_count;
  int unsigned useful_events;
  bit          beat_taken;

  // generator view of direction and run state, to steer sequences
  bit gen_up;
  bit gen_run;

  // predicted counter: index 0 seconds, 1 minutes, 2 hours
  bcd_field_t clock_digits [3];
  bit         clock_up;
  bit         clock_run;
  bit         clock_alarm;

  // ---------------------------------------------------------------- predictor

  function automatic bit field_full(bcd_field_t f);
    return f.units >= UNITS_MAX && f.tens >= TENS_MAX;
  endfunction

  // manual adjust: saturates at 59 and 00
  function automatic bcd_field_t field_adjust(bcd_field_t f, bit up);
    if (up) begin
      if (f.units >= UNITS_MAX) begin
        if (f.tens >= TENS_MAX) begin
          f.units = UNITS_MAX;
          f.tens  = TENS_MAX;
        end else begin
          f.units = '0;
          f.tens  = f.tens + 3'd1;
        end
      end else begin
        f.units = f.units + 4'd1;
      end
    end else begin
      if (f.units == '0) begin
        if (f.tens != '0) begin
          f.units = UNITS_MAX;
          f.tens  = f.tens - 3'd1;
        end
      end else begin
        f.units = f.units - 4'd1;
      end
    end
    return f;
  endfunction

  // tick step of one field with wrap; returns carry or borrow out
  function automatic bit field_roll(int idx, bit up);
    if (up) begin
      if (clock_digits[idx].units < UNITS_MAX) begin
        clock_digits[idx].units = clock_digits[idx].units + 4'd1;
        return 1'b0;
      end
      clock_digits[idx].units = '0;
      if (clock_digits[idx].tens < TENS_MAX) begin
        clock_digits[idx].tens = clock_digits[idx].tens + 3'd1;
        return 1'b0;
      end
      clock_digits[idx].tens = '0;
      return 1'b1;
    end
    if (clock_digits[idx].units != '0) begin
      clock_digits[idx].units = clock_digits[idx].units - 4'd1;
      return 1'b0;
    end
    clock_digits[idx].units = UNITS_MAX;
    if (clock_digits[idx].tens != '0) begin
      clock_digits[idx].tens = clock_digits[idx].tens - 3'd1;
      return 1'b0;
    end
    clock_digits[idx].tens = TENS_MAX;
    return 1'b1;
  endfunction

  task automatic reset_clock();
    for (int i = 0; i < 3; i++) clock_digits[i] = '0;
    clock_up    = 1'b1;
    clock_run   = 1'b1;
    clock_alarm = 1'b0;
  endtask

  function automatic out_item_t apply_event(in_item_t ev);
    out_item_t snap;
    case (ev.kind)
      KIND_TICK: begin
        if (clock_run) begin
          clock_alarm = 1'b0;
          if (clock_up) begin
            if (field_full(clock_digits[FIELD_SEC]) && field_full(clock_digits[FIELD_MIN]) &&
                field_full(clock_digits[FIELD_HRS])) begin
              for (int i = 0; i < 3; i++) begin
                clock_digits[i].units = UNITS_MAX;
                clock_digits[i].tens  = TENS_MAX;
              end
            end else if (field_roll(FIELD_SEC, 1'b1)) begin
              if (field_roll(FIELD_MIN, 1'b1)) void'(field_roll(FIELD_HRS, 1'b1));
            end
          end else begin
            if (clock_digits[FIELD_SEC] == '0 && clock_digits[FIELD_MIN] == '0 &&
                clock_digits[FIELD_HRS] == '0) begin
              clock_alarm = 1'b1;
            end else if (field_roll(FIELD_SEC, 1'b0)) begin
              if (field_roll(FIELD_MIN, 1'b0)) void'(field_roll(FIELD_HRS, 1'b0));
            end
          end
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < 3; i++) clock_digits[i] = '0;
        clock_alarm = 1'b0;
      end
      KIND_PAUSE:  clock_run = 1'b0;
      KIND_RESUME: clock_run = 1'b1;
      KIND_TOGGLE: clock_up  = !clock_up;
      KIND_ADJ_UP, KIND_ADJ_DOWN: begin
        if (ev.field_select != FIELD_NONE) begin
          clock_digits[ev.field_select] =
            field_adjust(clock_digits[ev.field_select], ev.kind == KIND_ADJ_UP);
        end
      end
      default: ;
    endcase
    snap.sec_units_digit = clock_digits[FIELD_SEC].units;
    snap.sec_tens_digit  = clock_digits[FIELD_SEC].tens;
    snap.min_units_digit = clock_digits[FIELD_MIN].units;
    snap.min_tens_digit  = clock_digits[FIELD_MIN].tens;
    snap.hrs_units_digit = clock_digits[FIELD_HRS].units;
    snap.hrs_tens_digit  = clock_digits[FIELD_HRS].tens;
    snap.counting_up     = clock_up;
    snap.running         = clock_run;
    snap.alarm           = clock_alarm;
    return snap;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic compare_snapshot(out_item_t want, out_item_t got);
    check_field("sec_units_digit", want.sec_units_digit, got.sec_units_digit);
    check_field("sec_tens_digit", want.sec_tens_digit, got.sec_tens_digit);
    check_field("min_units_digit", want.min_units_digit, got.min_units_digit);
    check_field("min_tens_digit", want.min_tens_digit, got.min_tens_digit);
    check_field("hrs_units_digit", want.hrs_units_digit, got.hrs_units_digit);
    check_field("hrs_tens_digit", want.hrs_tens_digit, got.hrs_tens_digit);
    check_field("counting_up", want.counting_up, got.counting_up);
    check_field("running", want.running, got.running);
    check_field("alarm", want.alarm, got.alarm);
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic [1:0] any_field();
    return 2'($urandom_range(0, 3));
  endfunction

  task automatic push_event(logic [2:0] k, logic [1:0] s);
    in_item_t ev;
    bit       adj;
    ev.kind         = k;
    ev.field_select = s;
    adj = (k == KIND_ADJ_UP) || (k == KIND_ADJ_DOWN);
    pending_events.push_back(ev);
    // events the block simply ignores do not count
    if (!(k == KIND_UNUSED || (adj && s == FIELD_NONE) || (k == KIND_TICK && !gen_run)))
      useful_events++;
    if (k == KIND_TOGGLE) gen_up = !gen_up;
    if (k == KIND_PAUSE) gen_run = 1'b0;
    if (k == KIND_RESUME) gen_run = 1'b1;
  endtask

  task automatic set_mode(bit up);
    if (gen_up != up) push_event(KIND_TOGGLE, any_field());
    if (!gen_run) push_event(KIND_RESUME, any_field());
  endtask

  // walk every field to 59 and tick into the 59:59:59 ceiling, then back down
  task automatic run_to_top();
    push_event(KIND_CLEAR, any_field());
    for (int f = 0; f < 3; f++) repeat (60) push_event(KIND_ADJ_UP, 2'(f));
    set_mode(1'b1);
    repeat ($urandom_range(1, 4)) push_event(KIND_TICK, any_field());
    set_mode(1'b0);
    repeat ($urandom_range(1, 3)) push_event(KIND_TICK, any_field());
  endtask

  task automatic fill_directed();
    push_event(KIND_TICK, FIELD_SEC);        // 00:00:01 counting up
    push_event(KIND_ADJ_DOWN, FIELD_SEC);
    push_event(KIND_ADJ_DOWN, FIELD_SEC);    // saturate at 00
    push_event(KIND_ADJ_DOWN, FIELD_MIN);
    push_event(KIND_ADJ_UP, FIELD_HRS);
    push_event(KIND_ADJ_UP, FIELD_NONE);     // no field, ignored
    push_event(KIND_UNUSED, FIELD_NONE);
    push_event(KIND_TOGGLE, FIELD_MIN);
    push_event(KIND_TICK, FIELD_HRS);        // borrow through all fields
    push_event(KIND_CLEAR, FIELD_NONE);
    push_event(KIND_TICK, FIELD_SEC);        // down at zero raises alarm
    push_event(KIND_TICK, FIELD_SEC);
    push_event(KIND_PAUSE, FIELD_SEC);
    push_event(KIND_TICK, FIELD_SEC);        // paused, alarm kept
    push_event(KIND_ADJ_UP, FIELD_SEC);      // adjust leaves alarm alone
    push_event(KIND_RESUME, FIELD_HRS);
    push_event(KIND_TICK, FIELD_MIN);
    push_event(KIND_TICK, FIELD_MIN);
    push_event(KIND_CLEAR, FIELD_HRS);
    push_event(KIND_TOGGLE, FIELD_NONE);
    push_event(KIND_ADJ_UP, FIELD_MIN);
    push_event(KIND_ADJ_DOWN, FIELD_NONE);
    push_event(KIND_ADJ_DOWN, FIELD_HRS);
    push_event(KIND_TICK, FIELD_NONE);
  endtask

  task automatic fill_random();
    int unsigned pick;
    logic [2:0]  k;
    logic [1:0]  f;
    run_to_top();
    while (useful_events < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        if (!gen_run && $urandom_range(0, 1)) push_event(KIND_RESUME, any_field());
        repeat ($urandom_range(1, 40)) push_event(KIND_TICK, any_field());
      end else if (pick < 55) begin
        f = 2'($urandom_range(0, 2));
        k = $urandom_range(0, 1) ? KIND_ADJ_UP : KIND_ADJ_DOWN;
        repeat ($urandom_range(1, 65)) push_event(k, f);
      end else if (pick < 70) begin
        case ($urandom_range(0, 3))
          0:       push_event(KIND_CLEAR, any_field());
          1:       push_event(KIND_PAUSE, any_field());
          2:       push_event(KIND_RESUME, any_field());
          default: push_event(KIND_TOGGLE, any_field());
        endcase
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 8)) push_event(3'($urandom_range(0, 7)), any_field());
      end else if (pick < 95) begin
        // short countdown that reaches zero or borrows across a field
        push_event(KIND_CLEAR, any_field());
        f = 2'($urandom_range(0, 2));
        repeat ($urandom_range(1, 3)) push_event(KIND_ADJ_UP, f);
        set_mode(1'b0);
        repeat ($urandom_range(1, 8)) push_event(KIND_TICK, any_field());
      end else begin
        run_to_top();
      end
    end
  endtask

  // ---------------------------------------------------------------- clock, bfm

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit idle_now();
    if (cycle_count >= CALM_START && cycle_count < CALM_END) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      cycle_count++;
      stall_count++;
      if (out_ch.valid && out_ch.ready) begin
        stall_count = 0;
        if (expected_snapshots.size() == 0) begin
          error_count++;
          $display("%0t: result beat with nothing expected, expected none, got %h",
                   $time, out_ch.data);
        end else begin
          compare_snapshot(expected_snapshots.pop_front(), out_ch.data);
        end
      end
      beat_taken = in_ch.valid && in_ch.ready;
      if (beat_taken) begin
        stall_count = 0;
        void'(pending_events.pop_front());
        expected_snapshots.push_back(apply_event(in_ch.data));
      end
      if (stall_count >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, stall_count);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // driver: change inputs at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || beat_taken) begin
        if (pending_events.size() != 0 && !idle_now()) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_events[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= !idle_now();
    end
  end

  initial begin
    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cycle_count  = 0;
    stall_count  = 0;
    error_count  = 0;
    beat_taken   = 1'b0;
    gen_up       = 1'b1;
    gen_run      = 1'b1;
    reset_clock();
    fill_directed();
    fill_random();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_events.size() != 0 || expected_snapshots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_snapshots.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
